// ===== rtl/core/urbif_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package urbif_pkg;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_TX_EMPTY = 2'd1,
        OP_RX_BYTE  = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    // Result kinds reported on the result channel.
    typedef enum logic [2:0] {
        KIND_QUEUED     = 3'd0,
        KIND_QUEUE_FULL = 3'd1,
        KIND_BYTE_OUT   = 3'd2,
        KIND_TX_IDLE    = 3'd3,
        KIND_RX_STORED  = 3'd4,
        KIND_RX_OVERFLW = 3'd5,
        KIND_RX_DROPPED = 3'd6,
        KIND_FRAME_BYTE = 3'd7
    } kind_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/uart_ring_buffer_idle_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UART buffering engine with a transmit ring and an idle-timeout receive framer.
// Input channel: an item (operation, data_byte) is taken at a clock edge where
// start is high and busy is low. Items enter a two-entry queue; busy is high
// while that queue is full.
// Result channel: result_valid strobes for one cycle per result item; the
// receiver must take every strobe, there is no back pressure on this side.
// Path: an item passes the queue and then the registered result stage before
// its result strobes; a byte popped from the transmit ring or the first byte
// of a closed frame also passes the registered read of its store. An item that
// waits in the queue behind a busy execution unit adds its waiting time.
// Throughput: the execution unit takes one item per cycle for enqueue,
// receive and tick items while it is idle; a transmit pop, and a tick that
// closes a frame, hold it until their results are out, and the frame's bytes
// then stream one per cycle.
// Configuration: timeout_we writes timeout_wdata into the idle timeout; write
// only while no item is outstanding.
// Reset clears all pointers, counters, flags and the queue; the idle timeout
// returns to 10 ticks. Buffer contents are not cleared and need no clearing.
module uart_ring_buffer_idle_framer #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   operation,
    input  wire logic [7:0]   data_byte,
    input  wire logic         timeout_we,
    input  wire logic [15:0]  timeout_wdata,
    output logic              result_valid,
    output logic [2:0]        result_kind,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic [6:0]        frame_length,
    output logic [5:0]        tx_fill
);
    import urbif_pkg::*;

    logic  q_valid;
    logic  pop;
    item_t q_item;

    // Front: accept, classify and queue items.
    urbif_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .data_byte (data_byte),
        .pop       (pop),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back: execute items against the buffers and produce results.
    urbif_back #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .timeout_we    (timeout_we),
        .timeout_wdata (timeout_wdata),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .out_byte      (out_byte),
        .last          (last),
        .frame_length  (frame_length),
        .tx_fill       (tx_fill)
    );

endmodule

`default_nettype wire

// ===== rtl/core/urbif_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urbif_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [1:0]      operation,
    input  wire logic [7:0]      data_byte,
    input  wire logic            pop,
    output logic                 busy,
    output logic                 q_valid,
    output urbif_pkg::item_t     q_item
);
    import urbif_pkg::*;

    logic       push;
    item_t      in_item;
    item_t      q_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Classify the incoming operation and pack the item.
    always_comb
    begin
        in_item.op   = op_t'(operation);
        in_item.data = data_byte;
    end

    // The two-entry queue is full when both slots hold an item.
    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/urbif_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module urbif_back #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  urbif_pkg::item_t      q_item,
    input  wire logic             timeout_we,
    input  wire logic [15:0]      timeout_wdata,
    output logic                  pop,
    output logic                  result_valid,
    output logic [2:0]            result_kind,
    output logic [7:0]            out_byte,
    output logic                  last,
    output logic [6:0]            frame_length,
    output logic [5:0]            tx_fill
);
    import urbif_pkg::*;

    localparam int TX_AW  = $clog2(TX_DEPTH);
    localparam int RX_AW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_FW  = $clog2(RX_DEPTH + 1);
    localparam int FILL_W = TX_AW + 6;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_TXRD  = 3'b010,
        S_FRAME = 3'b100
    } state_t;

    state_t             state_reg,   state_next;
    logic [15:0]        timeout_reg, timeout_next;
    logic [TX_AW-1:0]   tx_head_reg, tx_head_next;
    logic [TX_AW-1:0]   tx_tail_reg, tx_tail_next;
    logic [TX_AW-1:0]   tx_count_reg, tx_count_next;
    logic               tx_active_reg, tx_active_next;
    logic [RX_FW-1:0]   rx_fill_reg, rx_fill_next;
    logic               rx_pending_reg, rx_pending_next;
    logic [15:0]        timer_reg,   timer_next;
    logic [RX_FW-1:0]   frm_len_reg, frm_len_next;
    logic [RX_FW-1:0]   frm_idx_reg, frm_idx_next;

    logic               res_valid_reg, res_valid_next;
    kind_t              res_kind_reg,  res_kind_next;
    logic [7:0]         res_byte_reg,  res_byte_next;
    logic               res_last_reg,  res_last_next;
    logic [6:0]         res_len_reg,   res_len_next;
    logic [5:0]         res_fill_reg,  res_fill_next;

    logic [7:0]         tx_mem [TX_DEPTH];
    logic [7:0]         rx_mem [RX_DEPTH];
    logic [7:0]         tx_rd_reg;
    logic [7:0]         rx_rd_reg;
    logic               tx_wr_en;
    logic               tx_rd_en;
    logic               rx_wr_en;
    logic               rx_rd_en;
    logic [RX_AW-1:0]   rx_rd_addr;

    logic [TX_AW-1:0]   tx_head_inc;
    logic [TX_AW-1:0]   tx_tail_inc;
    logic [RX_FW-1:0]   frm_idx_inc;
    logic               frm_last;
    logic [FILL_W-1:0]  fill_ext;

    // Ring pointer advance with wrap at the ring depth.
    assign tx_head_inc = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + 1'b1;
    assign frm_idx_inc = frm_idx_reg + 1'b1;
    assign frm_last    = (frm_idx_inc == frm_len_reg);

    // Execution sequencer: one item per pass through idle, frames stream one byte a cycle.
    always_comb
    begin
        state_next      = state_reg;
        timeout_next    = timeout_we ? timeout_wdata : timeout_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        tx_count_next   = tx_count_reg;
        tx_active_next  = tx_active_reg;
        rx_fill_next    = rx_fill_reg;
        rx_pending_next = rx_pending_reg;
        timer_next      = timer_reg;
        frm_len_next    = frm_len_reg;
        frm_idx_next    = frm_idx_reg;
        res_valid_next  = 1'b0;
        res_kind_next   = KIND_QUEUED;
        res_byte_next   = 8'd0;
        res_last_next   = 1'b0;
        res_len_next    = 7'd0;
        tx_wr_en        = 1'b0;
        tx_rd_en        = 1'b0;
        rx_wr_en        = 1'b0;
        rx_rd_en        = 1'b0;
        rx_rd_addr      = '0;
        pop             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    case (q_item.op)
                        OP_ENQUEUE:
                        begin
                            res_valid_next = 1'b1;
                            if (tx_head_inc == tx_tail_reg)
                            begin
                                res_kind_next = KIND_QUEUE_FULL;
                            end
                            else
                            begin
                                tx_wr_en       = 1'b1;
                                tx_head_next   = tx_head_inc;
                                tx_count_next  = tx_count_reg + 1'b1;
                                tx_active_next = 1'b1;
                                res_kind_next  = KIND_QUEUED;
                            end
                        end
                        OP_TX_EMPTY:
                        begin
                            if (tx_tail_reg != tx_head_reg)
                            begin
                                // The byte is reported once the ring read returns.
                                tx_rd_en      = 1'b1;
                                tx_tail_next  = tx_tail_inc;
                                tx_count_next = tx_count_reg - 1'b1;
                                state_next    = S_TXRD;
                            end
                            else
                            begin
                                tx_active_next = 1'b0;
                                tx_head_next   = '0;
                                tx_tail_next   = '0;
                                tx_count_next  = '0;
                                res_valid_next = 1'b1;
                                res_kind_next  = KIND_TX_IDLE;
                            end
                        end
                        OP_RX_BYTE:
                        begin
                            res_valid_next = 1'b1;
                            if (tx_active_reg)
                            begin
                                res_kind_next = KIND_RX_DROPPED;
                            end
                            else if (rx_fill_reg >= RX_FW'(RX_DEPTH))
                            begin
                                res_kind_next = KIND_RX_OVERFLW;
                            end
                            else
                            begin
                                rx_wr_en        = 1'b1;
                                rx_fill_next    = rx_fill_reg + 1'b1;
                                rx_pending_next = 1'b1;
                                timer_next      = 16'd0;
                                res_kind_next   = KIND_RX_STORED;
                            end
                        end
                        OP_TICK:
                        begin
                            if (rx_pending_reg)
                            begin
                                if (timer_reg != TIMER_MAX)
                                begin
                                    timer_next = timer_reg + 16'd1;
                                end
                                if (timer_reg >= timeout_reg)
                                begin
                                    // Close the frame and prefetch its first byte.
                                    rx_pending_next = 1'b0;
                                    timer_next      = 16'd0;
                                    frm_len_next    = rx_fill_reg;
                                    frm_idx_next    = '0;
                                    rx_rd_en        = 1'b1;
                                    rx_rd_addr      = '0;
                                    state_next      = S_FRAME;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TXRD:
            begin
                res_valid_next = 1'b1;
                res_kind_next  = KIND_BYTE_OUT;
                res_byte_next  = tx_rd_reg;
                state_next     = S_IDLE;
            end
            S_FRAME:
            begin
                res_valid_next = 1'b1;
                res_kind_next  = KIND_FRAME_BYTE;
                res_byte_next  = rx_rd_reg;
                res_last_next  = frm_last;
                res_len_next   = 7'(frm_len_reg);
                if (frm_last)
                begin
                    rx_fill_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    frm_idx_next = frm_idx_inc;
                    rx_rd_en     = 1'b1;
                    rx_rd_addr   = frm_idx_inc[RX_AW-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Every result reports the ring occupancy after the step, low six bits.
    assign fill_ext      = FILL_W'(tx_count_next);
    assign res_fill_next = fill_ext[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            timeout_reg    <= TIMEOUT_RESET;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            tx_count_reg   <= '0;
            tx_active_reg  <= 1'b0;
            rx_fill_reg    <= '0;
            rx_pending_reg <= 1'b0;
            timer_reg      <= 16'd0;
            frm_len_reg    <= '0;
            frm_idx_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            tx_count_reg   <= tx_count_next;
            tx_active_reg  <= tx_active_next;
            rx_fill_reg    <= rx_fill_next;
            rx_pending_reg <= rx_pending_next;
            timer_reg      <= timer_next;
            frm_len_reg    <= frm_len_next;
            frm_idx_reg    <= frm_idx_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_byte_reg <= res_byte_next;
        res_last_reg <= res_last_next;
        res_len_reg  <= res_len_next;
        res_fill_reg <= res_fill_next;
    end

    // Transmit ring storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (tx_wr_en)
        begin
            tx_mem[tx_head_reg] <= q_item.data;
        end
        if (tx_rd_en)
        begin
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    // Receive frame storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (rx_wr_en)
        begin
            rx_mem[rx_fill_reg[RX_AW-1:0]] <= q_item.data;
        end
        if (rx_rd_en)
        begin
            rx_rd_reg <= rx_mem[rx_rd_addr];
        end
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign out_byte     = res_byte_reg;
    assign last         = res_last_reg;
    assign frame_length = res_len_reg;
    assign tx_fill      = res_fill_reg;

    // The ring never holds more than depth minus one bytes.
    a_tx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(tx_count_reg) < TX_DEPTH))
        else $error("transmit ring count beyond capacity");

    // A pending frame always has at least one stored byte.
    a_pending_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rx_pending_reg |-> (rx_fill_reg != '0))
        else $error("pending frame with empty receive buffer");

    // While streaming, the byte index stays inside a non-empty frame.
    a_frame_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRAME) |-> (frm_len_reg != '0 && frm_idx_reg < frm_len_reg))
        else $error("frame index outside the frame");

    // A ring read is always followed by a byte-out result.
    a_txrd_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TXRD) |=> (res_valid_reg && res_kind_reg == KIND_BYTE_OUT))
        else $error("ring read without byte-out result");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import urbif_pkg::*;

    // One result item as the block reports it.
    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       last_flag;
        logic [6:0] flen;
        logic [5:0] fill;
    } uart_out_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic        timeout_we;
    logic [15:0] timeout_wdata;
    logic        result_valid;
    logic [2:0]  result_kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [6:0]  frame_length;
    logic [5:0]  tx_fill;

    // Our own copy of the buffering engine state.
    logic [7:0]  tx_mem [64];
    logic [5:0]  tx_wr = '0;
    logic [5:0]  tx_rd = '0;
    int          tx_level = 0;
    bit          tx_on = 1'b0;
    logic [7:0]  rx_mem [64];
    int          rx_level = 0;
    bit          frame_open = 1'b0;
    int          idle_count = 0;
    logic [15:0] timeout_cfg = TIMEOUT_RESET;

    // Results still owed by the block, oldest first.
    uart_out_t   uart_out_due [$];

    int          mismatch_count = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_frames = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;

    uart_ring_buffer_idle_framer #(
        .TX_DEPTH(64),
        .RX_DEPTH(64)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .data_byte    (data_byte),
        .timeout_we   (timeout_we),
        .timeout_wdata(timeout_wdata),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .out_byte     (out_byte),
        .last         (last),
        .frame_length (frame_length),
        .tx_fill      (tx_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("Timeout waiting for the block to finish");
        $display("Test completed with failures");
        $finish;
    end

    task automatic note_mismatch(string what);
        mismatch_count++;
        $display("%0t ns: MISMATCH %s", $realtime, what);
    endtask

    function automatic void push_out(kind_t k, logic [7:0] v, logic lf, logic [6:0] fl);
        uart_out_t r;
        r.kind      = k;
        r.value     = v;
        r.last_flag = lf;
        r.flen      = fl;
        r.fill      = tx_level[5:0];
        uart_out_due.push_back(r);
    endfunction

    // Advance the engine state by one item and queue the results it causes.
    function automatic void apply_uart_event(op_t op, logic [7:0] d);
        logic [5:0] nxt;
        int         old_idle;
        int         n;
        nxt = tx_wr + 6'd1;
        case (op)
            OP_ENQUEUE:
            begin
                if (nxt == tx_rd)
                begin
                    push_out(KIND_QUEUE_FULL, 8'd0, 1'b0, 7'd0);
                end
                else
                begin
                    tx_mem[tx_wr] = d;
                    tx_wr = nxt;
                    tx_level++;
                    tx_on = 1'b1;
                    push_out(KIND_QUEUED, 8'd0, 1'b0, 7'd0);
                end
            end
            OP_TX_EMPTY:
            begin
                if (tx_rd != tx_wr)
                begin
                    n = tx_mem[tx_rd];
                    tx_rd = tx_rd + 6'd1;
                    tx_level--;
                    push_out(KIND_BYTE_OUT, 8'(n), 1'b0, 7'd0);
                end
                else
                begin
                    // An empty ring ends transmit mode and rewinds the pointers.
                    tx_on = 1'b0;
                    tx_wr = '0;
                    tx_rd = '0;
                    tx_level = 0;
                    push_out(KIND_TX_IDLE, 8'd0, 1'b0, 7'd0);
                end
            end
            OP_RX_BYTE:
            begin
                if (tx_on)
                begin
                    push_out(KIND_RX_DROPPED, 8'd0, 1'b0, 7'd0);
                end
                else if (rx_level >= 64)
                begin
                    push_out(KIND_RX_OVERFLW, 8'd0, 1'b0, 7'd0);
                end
                else
                begin
                    rx_mem[rx_level] = d;
                    rx_level++;
                    frame_open = 1'b1;
                    idle_count = 0;
                    push_out(KIND_RX_STORED, 8'd0, 1'b0, 7'd0);
                end
            end
            default:
            begin
                // Tick: the timer only runs while a frame is open.
                if (frame_open)
                begin
                    old_idle = idle_count;
                    if (idle_count < 65535)
                    begin
                        idle_count++;
                    end
                    if (old_idle >= int'(timeout_cfg))
                    begin
                        frame_open = 1'b0;
                        idle_count = 0;
                        n = rx_level;
                        for (int i = 0; i < n; i++)
                        begin
                            push_out(KIND_FRAME_BYTE, rx_mem[i], i == n - 1, 7'(n));
                        end
                        rx_level = 0;
                        n_frames++;
                    end
                end
            end
        endcase
    endfunction

    // Present one item, wait until the block takes it, then idle per the burst pattern.
    task automatic send_item(op_t op, logic [7:0] d);
        start     <= 1'b1;
        operation <= op;
        data_byte <= d;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        apply_uart_event(op, d);
        n_items++;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(0, 10);
                repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 25 : 5))
                    @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and let every owed result come out, plus pipeline slack.
    task automatic hold_until_drained();
        start <= 1'b0;
        while (uart_out_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] ticks);
        timeout_we    <= 1'b1;
        timeout_wdata <= ticks;
        @(posedge clk);
        timeout_we    <= 1'b0;
        timeout_cfg = ticks;
    endtask

    // Every operation and several corners of the engine, with the reset timeout, then with a timeout of zero.
    task automatic test_directed();
        send_item(OP_TX_EMPTY, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_RX_BYTE, 8'h00);
        send_item(OP_RX_BYTE, 8'hFF);
        send_item(OP_ENQUEUE, 8'hFF);
        send_item(OP_ENQUEUE, 8'h00);
        // Receive is masked while transmitting.
        send_item(OP_RX_BYTE, 8'hA5);
        send_item(OP_TX_EMPTY, 8'h5A);
        send_item(OP_TX_EMPTY, 8'h00);
        send_item(OP_TX_EMPTY, 8'h00);
        send_item(OP_TX_EMPTY, 8'hFF);
        // The frame closes on the tick that sees the timer at the timeout.
        repeat (11) send_item(OP_TICK, 8'(8'h55));
        hold_until_drained();
        write_timeout(16'd0);
        send_item(OP_RX_BYTE, 8'h5A);
        send_item(OP_TICK, 8'h00);
        hold_until_drained();
    endtask

    // Fill the ring until it refuses, wrap the pointers, then drain it.
    task automatic test_ring_full();
        repeat (64) send_item(OP_ENQUEUE, 8'($urandom));
        send_item(OP_TX_EMPTY, 8'($urandom));
        send_item(OP_ENQUEUE, 8'($urandom));
        send_item(OP_ENQUEUE, 8'($urandom));
        send_item(OP_RX_BYTE, 8'($urandom));
        repeat (64) send_item(OP_TX_EMPTY, 8'($urandom));
        hold_until_drained();
    endtask

    // Overrun the receive buffer and deliver the largest frame.
    task automatic test_rx_overflow();
        write_timeout(16'd3);
        repeat (66) send_item(OP_RX_BYTE, 8'($urandom));
        // A full buffer and transmit mode together report the drop.
        send_item(OP_ENQUEUE, 8'($urandom));
        send_item(OP_RX_BYTE, 8'($urandom));
        send_item(OP_TX_EMPTY, 8'($urandom));
        send_item(OP_TX_EMPTY, 8'($urandom));
        repeat (4) send_item(OP_TICK, 8'($urandom));
        hold_until_drained();
    endtask

    // Largest timeout keeps the frame open; then lower it mid-frame.
    task automatic test_timeout_extremes();
        write_timeout(16'hFFFF);
        no_gaps = 1'b1;
        send_item(OP_RX_BYTE, 8'($urandom));
        send_item(OP_RX_BYTE, 8'($urandom));
        repeat (6) send_item(OP_TICK, 8'($urandom));
        no_gaps = 1'b0;
        send_item(OP_RX_BYTE, 8'($urandom));
        repeat (5) send_item(OP_TICK, 8'($urandom));
        hold_until_drained();
        write_timeout(16'd0);
        send_item(OP_TICK, 8'($urandom));
        hold_until_drained();
        write_timeout(16'd2);
    endtask

    // Mostly well-formed transmit bursts and receive frames, some noise.
    task automatic test_random();
        int n;
        int k;
        while (n_items < 400)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 8);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_item(OP_RX_BYTE, 8'($urandom));
                        send_item(OP_ENQUEUE, 8'($urandom));
                    end
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, tx_level)
                                                    : tx_level + $urandom_range(1, 2);
                    repeat (k) send_item(OP_TX_EMPTY, 8'($urandom));
                end
                3, 4, 5, 6:
                begin
                    while (tx_on)
                        send_item(OP_TX_EMPTY, 8'($urandom));
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 8);
                    repeat (n) send_item(OP_RX_BYTE, 8'($urandom));
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(timeout_cfg))
                                                    : int'(timeout_cfg) + 1;
                    repeat (k) send_item(OP_TICK, 8'($urandom));
                end
                7, 8:
                begin
                    repeat ($urandom_range(1, 6))
                        send_item(op_t'($urandom_range(0, 3)), 8'($urandom));
                end
                default:
                begin
                    hold_until_drained();
                    case ($urandom_range(0, 3))
                        0:       write_timeout(16'd0);
                        1:       write_timeout(16'd1);
                        2:       write_timeout(16'($urandom_range(2, 5)));
                        default: write_timeout(16'($urandom_range(6, 12)));
                    endcase
                end
            endcase
        end
        hold_until_drained();
    endtask

    // Each strobed result is compared with the oldest owed result.
    always @(posedge clk)
    begin : check_results
        uart_out_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            n_results++;
            if (uart_out_due.size() == 0)
            begin
                note_mismatch($sformatf("result kind %0d with nothing owed", result_kind));
            end
            else
            begin
                want = uart_out_due.pop_front();
                if (result_kind !== want.kind)
                    note_mismatch($sformatf("result_kind %0d, want %0d",
                                            result_kind, want.kind));
                if (out_byte !== want.value)
                    note_mismatch($sformatf("out_byte %02h, want %02h",
                                            out_byte, want.value));
                if (last !== want.last_flag)
                    note_mismatch($sformatf("last %b, want %b", last, want.last_flag));
                if (frame_length !== want.flen)
                    note_mismatch($sformatf("frame_length %0d, want %0d",
                                            frame_length, want.flen));
                if (tx_fill !== want.fill)
                    note_mismatch($sformatf("tx_fill %0d, want %0d", tx_fill, want.fill));
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        operation     <= OP_ENQUEUE;
        data_byte     <= 8'd0;
        timeout_we    <= 1'b0;
        timeout_wdata <= 16'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_ring_full();
        test_rx_overflow();
        test_timeout_extremes();
        test_random();

        if (uart_out_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", uart_out_due.size()));
        $display("Run covered %0d items, %0d results, %0d frames closed on idle timeout.",
                 n_items, n_results, n_frames);
        $display("Ring full and wrap, receive overrun and masking, timeouts 0 to 65535; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/urbif_pkg.sv
rtl/core/urbif_front.sv
rtl/core/urbif_back.sv
rtl/core/uart_ring_buffer_idle_framer.sv
sim/tb.sv
